/* rtl/bls_pkg.sv */
// Shared types and constants for the bounded LIFO stack.
package bls_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_BOTTOM = 3'd3,
    OP_DRAIN  = 3'd4
  } op_t;

  localparam logic [31:0] EMPTY_PATTERN = 32'hBF80_0000;
  localparam int unsigned FILL_OUT_W = 8;

  typedef struct packed {
    logic [31:0]           data;
    logic                  was_empty;
    logic                  dropped;
    logic [FILL_OUT_W-1:0] fill;
  } res_t;

endpackage

/* rtl/bls_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module bls_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bounded_lifo_stack.sv */
// Bounded LIFO stack of 32-bit words: request decode, word RAM and result queue.
//
// Usage:
//   A request (in_op, in_value) transfers when in_valid is high and in_stall
//   is low. Each request produces exactly one result (out_data,
//   out_was_empty, out_dropped, out_fill), which transfers when out_valid is
//   high and out_stall is low. Results leave in request order.
//   A result passes through the read stage (registered RAM read) and then
//   the output register at the queue head before it is presented.
//   Throughput: one request per cycle while in_stall is low. Each request
//   touches at most one RAM word, either writing it or reading it, so
//   requests in consecutive cycles never meet at the same RAM port.
//   A two-entry result queue sits on the output. in_stall rises only when
//   the queue, together with the request in the read stage, would overflow,
//   so a stalled receiver holds back requests after two pending results.
//   Reset (rst_n low, synchronous) empties the stack and discards pending
//   results; the RAM contents are not cleared, as only words below the fill
//   count are ever read.
module bounded_lifo_stack #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_op,
  input  logic [31:0]                    in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_data,
  output logic                           out_was_empty,
  output logic                           out_dropped,
  output logic [bls_pkg::FILL_OUT_W-1:0] out_fill
);

  import bls_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_FILL = FW'(STACK_DEPTH);

  logic [FW-1:0] fill_r, fill_nxt;
  logic          st_valid_r;
  res_t          st_r, st_nxt;
  logic          st_use_ram_r, st_use_ram_nxt;
  logic [1:0]    q_cnt_r, q_cnt_nxt;
  res_t          head_r, head_nxt;
  res_t          skid_r, skid_nxt;

  logic          accept;
  logic          pop;
  logic          empty;
  logic          full;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [FW+FILL_OUT_W-1:0] fill_ext;
  res_t          stage_res;

  assign pop      = (q_cnt_r != 2'd0) && !out_stall;
  // A request may enter only if its result is sure of a queue slot next cycle.
  assign in_stall = (3'(q_cnt_r) + 3'(st_valid_r) - 3'(pop)) > 3'd1;
  assign accept   = in_valid && !in_stall;

  assign empty = (fill_r == '0);
  assign full  = (fill_r == DEPTH_FILL);

  always_comb begin
    fill_nxt       = fill_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    st_use_ram_nxt = 1'b0;
    st_nxt.data    = '0;
    st_nxt.dropped = 1'b0;
    unique case (op_t'(in_op))
      OP_PUSH: begin
        if (full) begin
          st_nxt.dropped = 1'b1;
        end else begin
          ram_we   = 1'b1;
          fill_nxt = fill_r + FW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          st_nxt.data = EMPTY_PATTERN;
        end else begin
          ram_re         = 1'b1;
          ram_raddr      = AW'(fill_r - FW'(1));
          st_use_ram_nxt = 1'b1;
          fill_nxt       = fill_r - FW'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          st_nxt.data = EMPTY_PATTERN;
        end else begin
          ram_re         = 1'b1;
          ram_raddr      = AW'(fill_r - FW'(1));
          st_use_ram_nxt = 1'b1;
        end
      end
      OP_BOTTOM: begin
        if (empty) begin
          st_nxt.data = EMPTY_PATTERN;
        end else begin
          ram_re         = 1'b1;
          st_use_ram_nxt = 1'b1;
        end
      end
      OP_DRAIN: begin
        if (!empty) begin
          ram_re         = 1'b1;
          st_use_ram_nxt = 1'b1;
        end
        fill_nxt = '0;
      end
      default: begin
      end
    endcase
    fill_ext         = {{FILL_OUT_W{1'b0}}, fill_nxt};
    st_nxt.was_empty = empty;
    st_nxt.fill      = fill_ext[FILL_OUT_W-1:0];
  end

  bls_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH),
    .ADDR_W(AW)
  ) u_word_ram (
    .clk  (clk),
    .we   (accept && ram_we),
    .waddr(fill_r[AW-1:0]),
    .wdata(in_value),
    .re   (accept && ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    stage_res      = st_r;
    stage_res.data = st_use_ram_r ? ram_rdata : st_r.data;
  end

  // Two-entry result queue: head_r drives the ports, skid_r catches overflow.
  always_comb begin
    q_cnt_nxt = q_cnt_r;
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    case (q_cnt_r)
      2'd0: begin
        if (st_valid_r) begin
          head_nxt  = stage_res;
          q_cnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (st_valid_r && pop) begin
          head_nxt = stage_res;
        end else if (st_valid_r) begin
          skid_nxt  = stage_res;
          q_cnt_nxt = 2'd2;
        end else if (pop) begin
          q_cnt_nxt = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_nxt = skid_r;
          if (st_valid_r) begin
            skid_nxt = stage_res;
          end else begin
            q_cnt_nxt = 2'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      st_valid_r <= 1'b0;
      q_cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
      end
      st_valid_r <= accept;
      q_cnt_r    <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r         <= st_nxt;
      st_use_ram_r <= st_use_ram_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = (q_cnt_r != 2'd0);
  assign out_data      = head_r.data;
  assign out_was_empty = head_r.was_empty;
  assign out_dropped   = head_r.dropped;
  assign out_fill      = head_r.fill;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("result queue holds more than two entries");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_FILL)
    else $error("fill count beyond stack depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid_r && (q_cnt_r == 2'd2) |-> pop)
    else $error("read stage result lands in a full result queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == OP_PUSH) && !full |=> fill_r == $past(fill_r) + FW'(1))
    else $error("accepted push did not advance the fill count");

  a_drop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_was_empty)
    else $error("dropped push reported on an empty stack");

endmodule
